@@ hw/rtl/ntct_pkg.sv @@
// Package for the NTC code-to-temperature converter: widths, codes, state type
// and the thermistor code table. No dependencies.
package ntct_pkg;

    localparam int CodeW      = 10;               // ADC code width
    localparam int CodeQW     = 16;               // code in Q10.6
    localparam int TempW      = 8;                // signed temperature
    localparam int StatW      = 2;
    localparam int TableDef   = 37;               // points defined in the table
    localparam int TableIdxW  = $clog2(TableDef);
    localparam int TablePts   = 37;               // default point count
    localparam int TempBase   = -55;              // temperature of point 0
    localparam int FaultTemp  = -127;
    localparam int DenW       = 16;               // segment width in Q10.6
    localparam int NumW       = 25;               // magnitude of interpolation numerator
    localparam int PAddrW     = 4;
    localparam int PDataW     = 32;

    localparam logic [CodeW-1:0] ShortRst    = 10'd35;
    localparam logic [CodeW-1:0] OverheatRst = 10'd96;
    localparam logic [CodeW-1:0] OpenRst     = 10'd990;

    typedef enum logic [StatW-1:0] {
        ST_NORMAL   = 2'd0,
        ST_OVERHEAT = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OPEN     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_SHORT    = 2'd0,
        REG_OVERHEAT = 2'd1,
        REG_OPEN     = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PREP,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [NumW-1:0] quot;
    } t_div_rsp;

    // Divider code at -55, -50, ... 125 C, Q10.6, descending.
    function automatic logic [CodeQW-1:0] code_q6(input logic [TableIdxW-1:0] idx);
        logic [CodeQW-1:0] v;
        case (idx)
            6'd0:  v = 16'd62435;
            6'd1:  v = 16'd61158;
            6'd2:  v = 16'd59482;
            6'd3:  v = 16'd57345;
            6'd4:  v = 16'd54703;
            6'd5:  v = 16'd51558;
            6'd6:  v = 16'd47932;
            6'd7:  v = 16'd43933;
            6'd8:  v = 16'd39680;
            6'd9:  v = 16'd35350;
            6'd10: v = 16'd31091;
            6'd11: v = 16'd27060;
            6'd12: v = 16'd23350;
            6'd13: v = 16'd20037;
            6'd14: v = 16'd17134;
            6'd15: v = 16'd14643;
            6'd16: v = 16'd12529;
            6'd17: v = 16'd10755;
            6'd18: v = 16'd9277;
            6'd19: v = 16'd8054;
            6'd20: v = 16'd7042;
            6'd21: v = 16'd6206;
            6'd22: v = 16'd5518;
            6'd23: v = 16'd4948;
            6'd24: v = 16'd4478;
            6'd25: v = 16'd4087;
            6'd26: v = 16'd3764;
            6'd27: v = 16'd3494;
            6'd28: v = 16'd3268;
            6'd29: v = 16'd3079;
            6'd30: v = 16'd2920;
            6'd31: v = 16'd2785;
            6'd32: v = 16'd2672;
            6'd33: v = 16'd2576;
            6'd34: v = 16'd2494;
            6'd35: v = 16'd2423;
            6'd36: v = 16'd2362;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/ntct_if.sv @@
// Valid/ready channel interfaces for the converter: ADC code in, result out.
// Depends on ntct_pkg.
interface ntct_in_if;
    logic                       valid;
    logic                       ready;
    logic [ntct_pkg::CodeW-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface ntct_out_if;
    logic                       valid;
    logic                       ready;
    logic [ntct_pkg::TempW-1:0] temperature;
    logic [ntct_pkg::StatW-1:0] sensor_status;

    modport source (output valid, output temperature, output sensor_status, input ready);
    modport sink   (input valid, input temperature, input sensor_status, output ready);
endinterface

@@ hw/rtl/ntct_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ntct_pkg (request/response structs).
module ntct_div #(
    parameter int NUM_W = ntct_pkg::NumW,
    parameter int DEN_W = ntct_pkg::DenW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntct_pkg::t_div_req  i_req,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    output ntct_pkg::t_div_rsp  o_rsp
);

    localparam int CntW = $clog2(NUM_W + 1);

    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W+1:0] w_trial;

    assign w_shift = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[DEN_W+1]) begin
                r_rem <= w_trial[DEN_W:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ hw/rtl/ntct_code_to_temperature_top.sv @@
// NTC thermistor code-to-temperature converter, top level.
// Depends on ntct_pkg, ntct_if (channels) and ntct_div (serial divider).
//
// Usage:
//   i_item carries one 10-bit ADC code per transaction; o_result returns one
//   transaction per code: a signed 8-bit temperature in C and a 2-bit sensor
//   status (normal, overheat, shorted, open). Shorted and open give -127.
//   The APB port holds three 10-bit limits at 0x0 (short), 0x4 (overheat)
//   and 0x8 (open); write them only while no conversion is in flight.
// Operation:
//   The code is compared against the table one point per cycle until the
//   bracketing segment is found, then the segment end points are fetched,
//   one multiply forms the interpolation numerator, and a restoring divider
//   produces one quotient bit per cycle.
// Flow:
//   One code is converted at a time; i_item.ready is high only while the
//   sequencer is idle, which includes the time a finished result still
//   waits in the output register.
// Reset / stall:
//   Synchronous active-low reset returns the sequencer to idle, empties the
//   output register and loads the limit defaults (35, 96, 990). If the sink
//   stalls, the result holds in the output register; a following result
//   waits in the done state until the register frees.
module ntc_code_to_temperature_top #(
    parameter int TABLE_POINTS = ntct_pkg::TablePts
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ntct_in_if.sink                       i_item,
    ntct_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ntct_pkg::PAddrW-1:0]   paddr,
    input  logic [ntct_pkg::PDataW-1:0]   pwdata,
    output logic [ntct_pkg::PDataW-1:0]   prdata,
    output logic                          pready
);

    // Points actually used: clamped to [2, points defined].
    localparam int NUsed = (TABLE_POINTS < ntct_pkg::TableDef)
                         ? ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS)
                         : ntct_pkg::TableDef;
    localparam int IdxW  = $clog2(NUsed);
    localparam int TIW   = ntct_pkg::TableIdxW;
    localparam int CW    = ntct_pkg::CodeW;
    localparam int QW    = ntct_pkg::CodeQW;
    localparam int TW    = ntct_pkg::TempW;
    localparam int DW    = ntct_pkg::DenW;
    localparam int NW    = ntct_pkg::NumW;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NUsed - 1);

    // ---------------- configuration registers ----------------
    logic [CW-1:0] r_short_lim;
    logic [CW-1:0] r_overheat_lim;
    logic [CW-1:0] r_open_lim;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_lim    <= ntct_pkg::ShortRst;
            r_overheat_lim <= ntct_pkg::OverheatRst;
            r_open_lim     <= ntct_pkg::OpenRst;
        end else if (w_cfg_wr) begin
            unique case (ntct_pkg::t_reg_idx'(paddr[3:2]))
                ntct_pkg::REG_SHORT:    r_short_lim    <= pwdata[CW-1:0];
                ntct_pkg::REG_OVERHEAT: r_overheat_lim <= pwdata[CW-1:0];
                ntct_pkg::REG_OPEN:     r_open_lim     <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (ntct_pkg::t_reg_idx'(paddr[3:2]))
            ntct_pkg::REG_SHORT:    prdata = ntct_pkg::PDataW'(r_short_lim);
            ntct_pkg::REG_OVERHEAT: prdata = ntct_pkg::PDataW'(r_overheat_lim);
            ntct_pkg::REG_OPEN:     prdata = ntct_pkg::PDataW'(r_open_lim);
            default:                prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    ntct_pkg::t_state   r_state, n_state;
    ntct_pkg::t_div_req w_div_req;
    ntct_pkg::t_div_rsp w_div_rsp;

    logic              w_in_ready;
    logic              w_out_load;
    logic              w_hit;

    // datapath
    logic [QW-1:0]          r_c;         // code in Q10.6
    ntct_pkg::t_status      r_status;
    ntct_pkg::t_status      w_status;
    logic [IdxW-1:0]        r_idx;       // search index, then segment s
    logic [DW-1:0]          r_den;
    logic signed [QW:0]     r_dif;       // chi - c
    logic signed [TW-1:0]   r_thi;       // temperature at point s-1
    logic                   r_neg;
    logic [NW-1:0]          w_mag;       // numerator magnitude, loaded into the divider

    logic [IdxW-1:0]        w_km1;
    logic [QW-1:0]          w_chi;
    logic [QW-1:0]          w_clo;
    logic signed [NW:0]     w_prod;
    logic signed [NW:0]     w_five;
    logic signed [NW:0]     w_num;
    logic [TW-2:0]          w_sat;
    logic [TW-1:0]          w_tmag;
    logic [TW-1:0]          w_temp;

    // output register
    logic                   r_out_valid;
    logic [TW-1:0]          r_out_temp;
    ntct_pkg::t_status      r_out_stat;

    assign w_hit = (r_c >= ntct_pkg::code_q6(TIW'(r_idx)));

    always_comb begin
        if (i_item.adc_code < r_short_lim)
            w_status = ntct_pkg::ST_SHORT;
        else if (i_item.adc_code < r_overheat_lim)
            w_status = ntct_pkg::ST_OVERHEAT;
        else if (i_item.adc_code > r_open_lim)
            w_status = ntct_pkg::ST_OPEN;
        else
            w_status = ntct_pkg::ST_NORMAL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        w_in_ready      = 1'b0;
        w_div_req.start = 1'b0;
        w_out_load      = 1'b0;
        unique case (r_state)
            ntct_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_item.valid) n_state = ntct_pkg::S_SEARCH;
            end
            ntct_pkg::S_SEARCH: begin
                if (w_hit || (r_idx == LastIdx)) n_state = ntct_pkg::S_PREP;
            end
            ntct_pkg::S_PREP: begin
                n_state = ntct_pkg::S_MUL;
            end
            ntct_pkg::S_MUL: begin
                w_div_req.start = 1'b1;
                n_state         = ntct_pkg::S_DIV;
            end
            ntct_pkg::S_DIV: begin
                if (w_div_rsp.done) n_state = ntct_pkg::S_DONE;
            end
            ntct_pkg::S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_out_load = 1'b1;
                    n_state    = ntct_pkg::S_IDLE;
                end
            end
            default: n_state = ntct_pkg::S_IDLE;
        endcase
    end

    assign i_item.ready = w_in_ready;

    // Segment end points; r_idx >= 1 once the search is done.
    assign w_km1 = r_idx - 1'b1;
    assign w_chi = ntct_pkg::code_q6(TIW'(w_km1));
    assign w_clo = ntct_pkg::code_q6(TIW'(r_idx));

    // numerator = thi*den + 5*(chi - c)
    assign w_prod = (NW+1)'(r_thi) * (NW+1)'(signed'({1'b0, r_den}));
    assign w_five = ((NW+1)'(r_dif) <<< 2) + (NW+1)'(r_dif);
    assign w_num  = w_prod + w_five;
    assign w_mag  = w_num[NW] ? NW'(-w_num) : NW'(w_num);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ntct_pkg::S_IDLE: begin
                r_c      <= {i_item.adc_code, 6'b0};
                r_status <= w_status;
                r_idx    <= '0;
            end
            ntct_pkg::S_SEARCH: begin
                if (w_hit || (r_idx == LastIdx))
                    r_idx <= (r_idx == '0) ? IdxW'(1) : r_idx;
                else
                    r_idx <= r_idx + 1'b1;
            end
            ntct_pkg::S_PREP: begin
                r_den <= w_chi - w_clo;
                r_dif <= signed'({1'b0, w_chi}) - signed'({1'b0, r_c});
                // -55 + 5*(s-1), modulo 2^8
                r_thi <= signed'(TW'(ntct_pkg::TempBase) + (TW'(w_km1) << 2) + TW'(w_km1));
            end
            ntct_pkg::S_MUL: begin
                r_neg <= w_num[NW];
            end
            default: ;
        endcase
    end

    ntct_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_num   (w_mag),
        .i_den   (r_den),
        .o_rsp   (w_div_rsp)
    );

    // Truncated magnitude, saturated to 127, sign restored; faults force -127.
    assign w_sat  = (|w_div_rsp.quot[NW-1:TW-1]) ? {(TW-1){1'b1}} : w_div_rsp.quot[TW-2:0];
    assign w_tmag = {1'b0, w_sat};

    always_comb begin
        if ((r_status == ntct_pkg::ST_SHORT) || (r_status == ntct_pkg::ST_OPEN))
            w_temp = TW'(ntct_pkg::FaultTemp);
        else if (r_neg)
            w_temp = -w_tmag;
        else
            w_temp = w_tmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_temp <= w_temp;
            r_out_stat <= r_status;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.temperature   = r_out_temp;
    assign o_result.sensor_status = r_out_stat;

endmodule

@@ hw/rtl/ntct_chk.sv @@
// Port-level checker for the NTC converter, bound to the top level.
// Depends on ntct_pkg and ntc_code_to_temperature_top.
module ntct_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ntct_pkg::TempW-1:0] out_temp,
    input logic [ntct_pkg::StatW-1:0] out_stat
);

    // One code in flight: after a transaction the input side closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a conversion is running");

    // Fault status always carries the fault temperature.
    a_fault_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && ((out_stat == ntct_pkg::ST_SHORT) || (out_stat == ntct_pkg::ST_OPEN))
        |-> (out_temp == ntct_pkg::TempW'(ntct_pkg::FaultTemp)))
        else $error("fault status without fault temperature");

    // Saturation is symmetric: -128 never appears.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_temp != 8'h80))
        else $error("temperature outside saturation range");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_stat))
        else $error("result changed while stalled");

endmodule

bind ntc_code_to_temperature_top ntct_chk u_ntct_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_item.valid),
    .in_ready  (i_item.ready),
    .out_valid (o_result.valid),
    .out_ready (o_result.ready),
    .out_temp  (o_result.temperature),
    .out_stat  (o_result.sensor_status)
);
